[rtl/c65exu_pkg.sv]
// shared types, codes and helpers of the 6502 execute unit
package c65exu_pkg;

  typedef enum logic [5:0] {
    CMD_ADC = 6'd0,  CMD_SBC = 6'd1,  CMD_AND = 6'd2,  CMD_ORA = 6'd3,
    CMD_EOR = 6'd4,  CMD_CMP = 6'd5,  CMD_CPX = 6'd6,  CMD_CPY = 6'd7,
    CMD_BIT = 6'd8,  CMD_ASL = 6'd9,  CMD_LSR = 6'd10, CMD_ROL = 6'd11,
    CMD_ROR = 6'd12, CMD_INC = 6'd13, CMD_DEC = 6'd14, CMD_LDA = 6'd15,
    CMD_LDX = 6'd16, CMD_LDY = 6'd17, CMD_STA = 6'd18, CMD_STX = 6'd19,
    CMD_STY = 6'd20, CMD_INX = 6'd21, CMD_INY = 6'd22, CMD_DEX = 6'd23,
    CMD_DEY = 6'd24, CMD_TAX = 6'd25, CMD_TAY = 6'd26, CMD_TXA = 6'd27,
    CMD_TYA = 6'd28, CMD_TSX = 6'd29, CMD_TXS = 6'd30, CMD_CLC = 6'd31,
    CMD_SEC = 6'd32, CMD_CLI = 6'd33, CMD_SEI = 6'd34, CMD_CLD = 6'd35,
    CMD_SED = 6'd36, CMD_CLV = 6'd37, CMD_BCC = 6'd38, CMD_BCS = 6'd39,
    CMD_BEQ = 6'd40, CMD_BNE = 6'd41, CMD_BMI = 6'd42, CMD_BPL = 6'd43,
    CMD_BVC = 6'd44, CMD_BVS = 6'd45, CMD_NOP = 6'd46
  } cmd_t;

  localparam int FLAG_C = 0;
  localparam int FLAG_Z = 1;
  localparam int FLAG_I = 2;
  localparam int FLAG_D = 3;
  localparam int FLAG_B = 4;
  localparam int FLAG_U = 5;
  localparam int FLAG_V = 6;
  localparam int FLAG_N = 7;

  localparam logic [7:0] SP_RESET = 8'hFD;
  localparam logic [7:0] P_RESET  = 8'h24;

  typedef struct packed {
    logic [5:0]        cmd;
    logic [7:0]        operand;
    logic              to_accumulator;
    logic [15:0]       pc_now;
    logic signed [7:0] branch_offset;
  } item_t;

  typedef struct packed {
    logic [7:0]  mem_data;
    logic        mem_write;
    logic [15:0] next_pc;
    logic [1:0]  extra_cycles;
    logic [7:0]  acc_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  sp_out;
    logic [7:0]  flags_out;
  } result_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] s;
    logic [7:0] p;
  } regs_t;

  typedef struct packed {
    logic [7:0] mem_data;
    logic       mem_write;
    logic       taken;
  } exec_t;

  function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] r;
    r = p;
    r[FLAG_Z] = (v == 8'h00);
    r[FLAG_N] = v[7];
    return r;
  endfunction

endpackage

[rtl/c65exu_alu.sv]
// register and flag update, memory write data and branch condition
module c65exu_alu (
  input  c65exu_pkg::item_t item,
  input  c65exu_pkg::regs_t regs,
  output c65exu_pkg::regs_t regs_next,
  output c65exu_pkg::exec_t ex
);

  logic [7:0] m;
  logic [7:0] addend;
  logic [8:0] sum9;
  logic [7:0] cmp_reg;
  logic [8:0] diff9;
  logic [7:0] sh;
  logic       sh_c;
  logic [7:0] inc_m;
  logic [7:0] dec_m;
  logic       cin;

  assign cin = regs.p[c65exu_pkg::FLAG_C];

  always_comb begin
    m = item.operand;
    if ((item.cmd inside {c65exu_pkg::CMD_ASL, c65exu_pkg::CMD_LSR,
                          c65exu_pkg::CMD_ROL, c65exu_pkg::CMD_ROR}) && item.to_accumulator) begin
      m = regs.a;
    end
  end

  assign addend = (item.cmd == c65exu_pkg::CMD_SBC) ? ~m : m;
  assign sum9   = {1'b0, regs.a} + {1'b0, addend} + {8'h00, cin};
  assign inc_m  = m + 8'h01;
  assign dec_m  = m - 8'h01;
  assign diff9  = {1'b0, cmp_reg} - {1'b0, m};

  always_comb begin
    case (item.cmd)
      c65exu_pkg::CMD_CPX: cmp_reg = regs.x;
      c65exu_pkg::CMD_CPY: cmp_reg = regs.y;
      default:             cmp_reg = regs.a;
    endcase
  end

  always_comb begin
    case (item.cmd)
      c65exu_pkg::CMD_ASL: begin
        sh   = {m[6:0], 1'b0};
        sh_c = m[7];
      end
      c65exu_pkg::CMD_ROL: begin
        sh   = {m[6:0], cin};
        sh_c = m[7];
      end
      c65exu_pkg::CMD_ROR: begin
        sh   = {cin, m[7:1]};
        sh_c = m[0];
      end
      default: begin
        sh   = {1'b0, m[7:1]};
        sh_c = m[0];
      end
    endcase
  end

  always_comb begin
    regs_next = regs;
    ex        = '0;
    case (item.cmd)
      c65exu_pkg::CMD_ADC, c65exu_pkg::CMD_SBC: begin
        regs_next.a = sum9[7:0];
        regs_next.p = c65exu_pkg::set_nz(regs.p, sum9[7:0]);
        regs_next.p[c65exu_pkg::FLAG_C] = sum9[8];
        regs_next.p[c65exu_pkg::FLAG_V] = ~(regs.a[7] ^ addend[7]) & (regs.a[7] ^ sum9[7]);
      end
      c65exu_pkg::CMD_AND: begin
        regs_next.a = regs.a & m;
        regs_next.p = c65exu_pkg::set_nz(regs.p, regs.a & m);
      end
      c65exu_pkg::CMD_ORA: begin
        regs_next.a = regs.a | m;
        regs_next.p = c65exu_pkg::set_nz(regs.p, regs.a | m);
      end
      c65exu_pkg::CMD_EOR: begin
        regs_next.a = regs.a ^ m;
        regs_next.p = c65exu_pkg::set_nz(regs.p, regs.a ^ m);
      end
      c65exu_pkg::CMD_CMP, c65exu_pkg::CMD_CPX, c65exu_pkg::CMD_CPY: begin
        regs_next.p = c65exu_pkg::set_nz(regs.p, diff9[7:0]);
        regs_next.p[c65exu_pkg::FLAG_C] = ~diff9[8];
      end
      c65exu_pkg::CMD_BIT: begin
        regs_next.p[c65exu_pkg::FLAG_Z] = ((regs.a & m) == 8'h00);
        regs_next.p[c65exu_pkg::FLAG_N] = m[7];
        regs_next.p[c65exu_pkg::FLAG_V] = m[6];
      end
      c65exu_pkg::CMD_ASL, c65exu_pkg::CMD_LSR, c65exu_pkg::CMD_ROL,
      c65exu_pkg::CMD_ROR: begin
        regs_next.p = c65exu_pkg::set_nz(regs.p, sh);
        regs_next.p[c65exu_pkg::FLAG_C] = sh_c;
        if (item.to_accumulator) begin
          regs_next.a = sh;
        end else begin
          ex.mem_data  = sh;
          ex.mem_write = 1'b1;
        end
      end
      c65exu_pkg::CMD_INC: begin
        ex.mem_data  = inc_m;
        ex.mem_write = 1'b1;
        regs_next.p  = c65exu_pkg::set_nz(regs.p, inc_m);
      end
      c65exu_pkg::CMD_DEC: begin
        ex.mem_data  = dec_m;
        ex.mem_write = 1'b1;
        regs_next.p  = c65exu_pkg::set_nz(regs.p, dec_m);
      end
      c65exu_pkg::CMD_LDA: begin
        regs_next.a = m;
        regs_next.p = c65exu_pkg::set_nz(regs.p, m);
      end
      c65exu_pkg::CMD_LDX: begin
        regs_next.x = m;
        regs_next.p = c65exu_pkg::set_nz(regs.p, m);
      end
      c65exu_pkg::CMD_LDY: begin
        regs_next.y = m;
        regs_next.p = c65exu_pkg::set_nz(regs.p, m);
      end
      c65exu_pkg::CMD_STA: begin
        ex.mem_data  = regs.a;
        ex.mem_write = 1'b1;
      end
      c65exu_pkg::CMD_STX: begin
        ex.mem_data  = regs.x;
        ex.mem_write = 1'b1;
      end
      c65exu_pkg::CMD_STY: begin
        ex.mem_data  = regs.y;
        ex.mem_write = 1'b1;
      end
      c65exu_pkg::CMD_INX: begin
        regs_next.x = regs.x + 8'h01;
        regs_next.p = c65exu_pkg::set_nz(regs.p, regs.x + 8'h01);
      end
      c65exu_pkg::CMD_INY: begin
        regs_next.y = regs.y + 8'h01;
        regs_next.p = c65exu_pkg::set_nz(regs.p, regs.y + 8'h01);
      end
      c65exu_pkg::CMD_DEX: begin
        regs_next.x = regs.x - 8'h01;
        regs_next.p = c65exu_pkg::set_nz(regs.p, regs.x - 8'h01);
      end
      c65exu_pkg::CMD_DEY: begin
        regs_next.y = regs.y - 8'h01;
        regs_next.p = c65exu_pkg::set_nz(regs.p, regs.y - 8'h01);
      end
      c65exu_pkg::CMD_TAX: begin
        regs_next.x = regs.a;
        regs_next.p = c65exu_pkg::set_nz(regs.p, regs.a);
      end
      c65exu_pkg::CMD_TAY: begin
        regs_next.y = regs.a;
        regs_next.p = c65exu_pkg::set_nz(regs.p, regs.a);
      end
      c65exu_pkg::CMD_TXA: begin
        regs_next.a = regs.x;
        regs_next.p = c65exu_pkg::set_nz(regs.p, regs.x);
      end
      c65exu_pkg::CMD_TYA: begin
        regs_next.a = regs.y;
        regs_next.p = c65exu_pkg::set_nz(regs.p, regs.y);
      end
      c65exu_pkg::CMD_TSX: begin
        regs_next.x = regs.s;
        regs_next.p = c65exu_pkg::set_nz(regs.p, regs.s);
      end
      c65exu_pkg::CMD_TXS: regs_next.s = regs.x;
      c65exu_pkg::CMD_CLC: regs_next.p[c65exu_pkg::FLAG_C] = 1'b0;
      c65exu_pkg::CMD_SEC: regs_next.p[c65exu_pkg::FLAG_C] = 1'b1;
      c65exu_pkg::CMD_CLI: regs_next.p[c65exu_pkg::FLAG_I] = 1'b0;
      c65exu_pkg::CMD_SEI: regs_next.p[c65exu_pkg::FLAG_I] = 1'b1;
      c65exu_pkg::CMD_CLD: regs_next.p[c65exu_pkg::FLAG_D] = 1'b0;
      c65exu_pkg::CMD_SED: regs_next.p[c65exu_pkg::FLAG_D] = 1'b1;
      c65exu_pkg::CMD_CLV: regs_next.p[c65exu_pkg::FLAG_V] = 1'b0;
      c65exu_pkg::CMD_BCC: ex.taken = ~regs.p[c65exu_pkg::FLAG_C];
      c65exu_pkg::CMD_BCS: ex.taken = regs.p[c65exu_pkg::FLAG_C];
      c65exu_pkg::CMD_BEQ: ex.taken = regs.p[c65exu_pkg::FLAG_Z];
      c65exu_pkg::CMD_BNE: ex.taken = ~regs.p[c65exu_pkg::FLAG_Z];
      c65exu_pkg::CMD_BMI: ex.taken = regs.p[c65exu_pkg::FLAG_N];
      c65exu_pkg::CMD_BPL: ex.taken = ~regs.p[c65exu_pkg::FLAG_N];
      c65exu_pkg::CMD_BVC: ex.taken = ~regs.p[c65exu_pkg::FLAG_V];
      c65exu_pkg::CMD_BVS: ex.taken = regs.p[c65exu_pkg::FLAG_V];
      default: ;
    endcase
  end

endmodule

[rtl/c65exu_branch.sv]
// branch target and page crossing penalty
module c65exu_branch (
  input  logic [15:0]       pc_now,
  input  logic signed [7:0] branch_offset,
  input  logic              taken,
  output logic [15:0]       next_pc,
  output logic [1:0]        extra_cycles
);

  logic [15:0] target;

  assign target = pc_now + {{8{branch_offset[7]}}, branch_offset};

  always_comb begin
    if (taken) begin
      next_pc      = target;
      extra_cycles = (target[15:8] != pc_now[15:8]) ? 2'd2 : 2'd1;
    end else begin
      next_pc      = pc_now;
      extra_cycles = 2'd0;
    end
  end

endmodule

[rtl/cpu_6502_execute_unit.sv]
// top level of the 6502 execute unit: input register, execute logic, result register
//
// usage
//   item channel: one decoded operation per transfer (item_valid, item_stall, item)
//   result channel: one result per item (result_valid, result_stall, result),
//     carrying the memory write, next pc, branch penalty and the registers after
//     the operation
//   execution: the item is executed from the input register once the result
//     register can take its result, against A, X, Y, S and P as left by the
//     item before it; the result is registered in the result register
//   throughput: one item per cycle while no result is stalled; the state
//     register update and the flag update are combinational, which sets the rate
//   stall: while result_stall holds a waiting result, the input register keeps
//     one more item and then item_stall rises; nothing is dropped or repeated
//   reset: A, X and Y clear, S goes to 0xFD, P to 0x24 (I and U set); both
//     registers empty
module cpu_6502_execute_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  c65exu_pkg::item_t   item,
  output logic                result_valid,
  input  logic                result_stall,
  output c65exu_pkg::result_t result
);

  logic              held_valid;
  c65exu_pkg::item_t held;
  c65exu_pkg::regs_t regs;
  c65exu_pkg::regs_t regs_next;
  c65exu_pkg::exec_t ex;
  logic [15:0]       next_pc;
  logic [1:0]        extra_cycles;
  logic              adv;
  logic              take;

  assign adv        = held_valid && (!result_valid || !result_stall);
  assign item_stall = held_valid && !adv;
  assign take       = item_valid && !item_stall;

  c65exu_alu u_alu (
    .item      (held),
    .regs      (regs),
    .regs_next (regs_next),
    .ex        (ex)
  );

  c65exu_branch u_branch (
    .pc_now        (held.pc_now),
    .branch_offset (held.branch_offset),
    .taken         (ex.taken),
    .next_pc       (next_pc),
    .extra_cycles  (extra_cycles)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= 1'b1;
    end else if (adv) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.a <= 8'h00;
      regs.x <= 8'h00;
      regs.y <= 8'h00;
      regs.s <= c65exu_pkg::SP_RESET;
      regs.p <= c65exu_pkg::P_RESET;
    end else if (adv) begin
      regs <= regs_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= adv || (result_valid && result_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.mem_data     <= ex.mem_data;
      result.mem_write    <= ex.mem_write;
      result.next_pc      <= next_pc;
      result.extra_cycles <= extra_cycles;
      result.acc_out      <= regs_next.a;
      result.x_out        <= regs_next.x;
      result.y_out        <= regs_next.y;
      result.sp_out       <= regs_next.s;
      result.flags_out    <= regs_next.p;
    end
  end

`ifndef SYNTHESIS
  a_reset_state: assert property (@(posedge clk)
    $past(rst) |-> (regs.s == c65exu_pkg::SP_RESET) && (regs.p == c65exu_pkg::P_RESET))
    else $error("state registers not at reset values");

  a_bu_fixed: assert property (@(posedge clk) disable iff (rst)
    regs.p[c65exu_pkg::FLAG_U:c65exu_pkg::FLAG_B] == 2'b10)
    else $error("b or u flag changed");

  a_regs_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(regs))
    else $error("state changed without an executed item");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.mem_write |-> result.mem_data == 8'h00)
    else $error("memory data without write strobe");

  a_extra_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.extra_cycles != 2'd3) &&
      ((result.extra_cycles == 2'd0) || (result.mem_write == 1'b0)))
    else $error("bad branch penalty");
`endif

endmodule

[sim/exu_result_checker.sv]
`timescale 1ns / 100ps
// checker for the 6502 execute unit: tracks A, X, Y, S and P, predicts each result, compares on transfer
module exu_result_checker
  import c65exu_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_stall,
  input  item_t   item,
  input  logic    result_valid,
  input  logic    result_stall,
  input  result_t result,
  output int      fail_count,
  output int      pending
);

  logic [7:0] reg_a;
  logic [7:0] reg_x;
  logic [7:0] reg_y;
  logic [7:0] reg_s;
  logic [7:0] reg_p;
  result_t    exec_outcomes[$];

  function void mark_nz(input logic [7:0] v);
    reg_p[FLAG_Z] = (v == 8'h00);
    reg_p[FLAG_N] = v[7];
  endfunction

  function void compare_to(input logic [7:0] lhs, input logic [7:0] rhs);
    reg_p[FLAG_C] = (lhs >= rhs);
    mark_nz(lhs - rhs);
  endfunction

  function automatic void execute_op(input item_t it, output result_t r);
    logic [7:0]  m;
    logic [7:0]  addend;
    logic [8:0]  sum;
    logic [7:0]  sh;
    logic        cout;
    logic        taken;
    logic [15:0] target;
    m = it.operand;
    r = '0;
    r.next_pc = it.pc_now;
    taken = 1'b0;
    if (it.cmd >= CMD_ASL && it.cmd <= CMD_ROR && it.to_accumulator) m = reg_a;
    case (it.cmd)
      CMD_ADC, CMD_SBC: begin
        addend = (it.cmd == CMD_SBC) ? ~m : m;
        sum = {1'b0, reg_a} + {1'b0, addend} + {8'h00, reg_p[FLAG_C]};
        reg_p[FLAG_C] = sum[8];
        reg_p[FLAG_V] = ~(reg_a[7] ^ addend[7]) & (reg_a[7] ^ sum[7]);
        reg_a = sum[7:0];
        mark_nz(reg_a);
      end
      CMD_AND: begin reg_a = reg_a & m; mark_nz(reg_a); end
      CMD_ORA: begin reg_a = reg_a | m; mark_nz(reg_a); end
      CMD_EOR: begin reg_a = reg_a ^ m; mark_nz(reg_a); end
      CMD_CMP: compare_to(reg_a, m);
      CMD_CPX: compare_to(reg_x, m);
      CMD_CPY: compare_to(reg_y, m);
      CMD_BIT: begin
        reg_p[FLAG_Z] = ((reg_a & m) == 8'h00);
        reg_p[FLAG_N] = m[7];
        reg_p[FLAG_V] = m[6];
      end
      CMD_ASL, CMD_LSR, CMD_ROL, CMD_ROR: begin
        case (it.cmd)
          CMD_ASL: begin sh = {m[6:0], 1'b0};          cout = m[7]; end
          CMD_LSR: begin sh = {1'b0, m[7:1]};          cout = m[0]; end
          CMD_ROL: begin sh = {m[6:0], reg_p[FLAG_C]}; cout = m[7]; end
          default: begin sh = {reg_p[FLAG_C], m[7:1]}; cout = m[0]; end
        endcase
        reg_p[FLAG_C] = cout;
        mark_nz(sh);
        if (it.to_accumulator) begin
          reg_a = sh;
        end else begin
          r.mem_data  = sh;
          r.mem_write = 1'b1;
        end
      end
      CMD_INC: begin r.mem_data = m + 8'd1; r.mem_write = 1'b1; mark_nz(r.mem_data); end
      CMD_DEC: begin r.mem_data = m - 8'd1; r.mem_write = 1'b1; mark_nz(r.mem_data); end
      CMD_LDA: begin reg_a = m; mark_nz(m); end
      CMD_LDX: begin reg_x = m; mark_nz(m); end
      CMD_LDY: begin reg_y = m; mark_nz(m); end
      CMD_STA: begin r.mem_data = reg_a; r.mem_write = 1'b1; end
      CMD_STX: begin r.mem_data = reg_x; r.mem_write = 1'b1; end
      CMD_STY: begin r.mem_data = reg_y; r.mem_write = 1'b1; end
      CMD_INX: begin reg_x = reg_x + 8'd1; mark_nz(reg_x); end
      CMD_INY: begin reg_y = reg_y + 8'd1; mark_nz(reg_y); end
      CMD_DEX: begin reg_x = reg_x - 8'd1; mark_nz(reg_x); end
      CMD_DEY: begin reg_y = reg_y - 8'd1; mark_nz(reg_y); end
      CMD_TAX: begin reg_x = reg_a; mark_nz(reg_x); end
      CMD_TAY: begin reg_y = reg_a; mark_nz(reg_y); end
      CMD_TXA: begin reg_a = reg_x; mark_nz(reg_a); end
      CMD_TYA: begin reg_a = reg_y; mark_nz(reg_a); end
      CMD_TSX: begin reg_x = reg_s; mark_nz(reg_x); end
      CMD_TXS: reg_s = reg_x;
      CMD_CLC: reg_p[FLAG_C] = 1'b0;
      CMD_SEC: reg_p[FLAG_C] = 1'b1;
      CMD_CLI: reg_p[FLAG_I] = 1'b0;
      CMD_SEI: reg_p[FLAG_I] = 1'b1;
      CMD_CLD: reg_p[FLAG_D] = 1'b0;
      CMD_SED: reg_p[FLAG_D] = 1'b1;
      CMD_CLV: reg_p[FLAG_V] = 1'b0;
      CMD_BCC: taken = !reg_p[FLAG_C];
      CMD_BCS: taken = reg_p[FLAG_C];
      CMD_BEQ: taken = reg_p[FLAG_Z];
      CMD_BNE: taken = !reg_p[FLAG_Z];
      CMD_BMI: taken = reg_p[FLAG_N];
      CMD_BPL: taken = !reg_p[FLAG_N];
      CMD_BVC: taken = !reg_p[FLAG_V];
      CMD_BVS: taken = reg_p[FLAG_V];
      default: ;
    endcase
    if (taken) begin
      target = it.pc_now + {{8{it.branch_offset[7]}}, it.branch_offset};
      r.next_pc = target;
      r.extra_cycles = (target[15:8] != it.pc_now[15:8]) ? 2'd2 : 2'd1;
    end
    r.acc_out   = reg_a;
    r.x_out     = reg_x;
    r.y_out     = reg_y;
    r.sp_out    = reg_s;
    r.flags_out = reg_p;
  endfunction

  function automatic int field_bad(input string name, input logic [15:0] exp_v,
                                   input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t predicted;
    int      errs;
    errs = 0;
    if (rst) begin
      reg_a = 8'h00;
      reg_x = 8'h00;
      reg_y = 8'h00;
      reg_s = SP_RESET;
      reg_p = P_RESET;
      exec_outcomes.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (exec_outcomes.size() == 0) begin
          $error("result transfer with no expectation waiting: %p", result);
          errs++;
        end else begin
          want = exec_outcomes.pop_front();
          errs += field_bad("mem_data", want.mem_data, result.mem_data);
          errs += field_bad("mem_write", want.mem_write, result.mem_write);
          errs += field_bad("next_pc", want.next_pc, result.next_pc);
          errs += field_bad("extra_cycles", want.extra_cycles, result.extra_cycles);
          errs += field_bad("acc_out", want.acc_out, result.acc_out);
          errs += field_bad("x_out", want.x_out, result.x_out);
          errs += field_bad("y_out", want.y_out, result.y_out);
          errs += field_bad("sp_out", want.sp_out, result.sp_out);
          errs += field_bad("flags_out", want.flags_out, result.flags_out);
        end
      end
      if (item_valid && !item_stall) begin
        execute_op(item, predicted);
        exec_outcomes.push_back(predicted);
      end
      if (errs != 0) fail_count <= fail_count + errs;
      pending <= exec_outcomes.size();
    end
  end

endmodule

[sim/tb_cpu_6502_execute_unit.sv]
`timescale 1ns / 100ps
// testbench top of the 6502 execute unit: clock, reset, operation traffic, result stalls, verdict
module tb_cpu_6502_execute_unit;
  import c65exu_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;
  int      fail_count;
  int      pending;
  int      idle_cycles = 0;
  bit      quiet_sender = 1'b0;

  cpu_6502_execute_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  exu_result_checker chk (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic issue(input logic [5:0] code, input logic [7:0] data, input logic acc,
                       input logic [15:0] pc, input logic [7:0] disp);
    item_t next_op;
    int    gap;
    int    r;
    gap = 0;
    if (!quiet_sender) begin
      r = $urandom_range(0, 99);
      if (r >= 92) gap = $urandom_range(8, 30);
      else if (r >= 65) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    next_op.cmd = code;
    next_op.operand = data;
    next_op.to_accumulator = acc;
    next_op.pc_now = pc;
    next_op.branch_offset = disp;
    item <= next_op;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // sender
  initial begin
    logic [5:0]  code;
    logic [7:0]  data;
    logic [15:0] pc;
    int          r;
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    issue(CMD_LDA, 8'h00, 1'b0, 16'h0200, 8'h00);
    issue(CMD_LDA, 8'h80, 1'b0, 16'h0202, 8'h00);
    issue(CMD_CLC, 8'h00, 1'b0, 16'h0204, 8'h00);
    issue(CMD_LDA, 8'h7F, 1'b0, 16'h0205, 8'h00);
    issue(CMD_ADC, 8'h01, 1'b0, 16'h0207, 8'h00);
    issue(CMD_ADC, 8'hFF, 1'b0, 16'h0209, 8'h00);
    issue(CMD_SEC, 8'h00, 1'b0, 16'h020B, 8'h00);
    issue(CMD_SBC, 8'h80, 1'b0, 16'h020C, 8'h00);
    issue(CMD_ASL, 8'hFF, 1'b1, 16'h020E, 8'h00);
    issue(CMD_ROR, 8'h01, 1'b0, 16'h020F, 8'h00);
    issue(CMD_INC, 8'hFF, 1'b0, 16'h0211, 8'h00);
    issue(CMD_DEC, 8'h00, 1'b0, 16'h0213, 8'h00);
    issue(CMD_LDX, 8'hFF, 1'b0, 16'h0215, 8'h00);
    issue(CMD_TXS, 8'h00, 1'b0, 16'h0217, 8'h00);
    issue(CMD_TSX, 8'h00, 1'b0, 16'h0218, 8'h00);
    issue(CMD_STA, 8'h55, 1'b0, 16'h0219, 8'h00);
    issue(CMD_CMP, 8'h80, 1'b0, 16'h021B, 8'h00);
    issue(CMD_BIT, 8'hC0, 1'b0, 16'h021D, 8'h00);
    issue(CMD_SEC, 8'h00, 1'b0, 16'h021F, 8'h00);
    issue(CMD_BCS, 8'h00, 1'b0, 16'hFFFF, 8'h01);
    issue(CMD_BCS, 8'h00, 1'b0, 16'h0000, 8'h80);
    issue(CMD_BCS, 8'h00, 1'b0, 16'h1234, 8'h7F);
    issue(CMD_BCC, 8'h00, 1'b0, 16'h1236, 8'h10);
    issue(6'd63, 8'hFF, 1'b1, 16'hFFFF, 8'hFF);
    issue(6'd47, 8'h00, 1'b0, 16'h0000, 8'h00);

    for (int n = 0; n < 400; n++) begin
      // one stretch of back-to-back items, gaps elsewhere
      quiet_sender = (n / 100) == 1;
      r = $urandom_range(0, 99);
      code = (r < 5) ? 6'($urandom_range(47, 63)) : 6'($urandom_range(0, 46));
      r = $urandom_range(0, 9);
      case (r)
        0: data = 8'h00;
        1: data = 8'hFF;
        2: data = 8'h80;
        3: data = 8'h7F;
        default: data = 8'($urandom_range(0, 255));
      endcase
      r = $urandom_range(0, 9);
      if (r < 2) pc = {8'hFF, 8'($urandom_range(0, 255))};
      else if (r < 3) pc = {8'h00, 8'($urandom_range(0, 255))};
      else pc = 16'($urandom_range(0, 65535));
      issue(code, data, 1'($urandom_range(0, 1)), pc, 8'($urandom_range(0, 255)));
    end
    item_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off once the block has produced a fair amount
  initial begin
    int hold = 0;
    int got = 0;
    int r;
    bit squeezed = 1'b0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (result_valid && !result_stall) got++;
      if (hold <= 0) begin
        if (!squeezed && got >= 150) begin
          squeezed = 1'b1;
          result_stall <= 1'b1;
          hold = 64;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 50) begin
            result_stall <= 1'b0;
            hold = $urandom_range(1, 6);
          end else if (r < 62) begin
            result_stall <= 1'b0;
            hold = $urandom_range(20, 60);
          end else if (r < 92) begin
            result_stall <= 1'b1;
            hold = $urandom_range(1, 3);
          end else begin
            result_stall <= 1'b1;
            hold = $urandom_range(8, 25);
          end
        end
      end
      hold--;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

[files.f]
rtl/c65exu_pkg.sv
rtl/c65exu_alu.sv
rtl/c65exu_branch.sv
rtl/cpu_6502_execute_unit.sv
sim/exu_result_checker.sv
sim/tb_cpu_6502_execute_unit.sv
